[rtl/fubd_pkg.sv]
package fubd_pkg;

    // Delimiter characters of a urlencoded body
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Byte classes found by the front part
    localparam logic [2:0] K_OTHER = 3'd0;
    localparam logic [2:0] K_AMP   = 3'd1;
    localparam logic [2:0] K_EQ    = 3'd2;
    localparam logic [2:0] K_PLUS  = 3'd3;
    localparam logic [2:0] K_PCT   = 3'd4;

    // Error codes on the result
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd1;
    localparam logic [2:0] ERR_TRUNC    = 3'd2;
    localparam logic [2:0] ERR_NO_EQ    = 3'd3;
    localparam logic [2:0] ERR_EXTRA_EQ = 3'd4;

    // Escape phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Queue depths and derived widths
    localparam int TQ_DEPTH = 4;
    localparam int TQ_AW    = $clog2(TQ_DEPTH);
    localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Classified byte passed from front to back
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       last;
    } t_token;

    // One result item
    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_byte;
        logic       in_value;
        logic       name_end;
        logic       pair_end;
        logic [2:0] error_code;
        logic       body_done;
    } t_result;

endpackage

[rtl/fubd_front.sv]
module fubd_front
    import fubd_pkg::*;
(
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_wr,
    output t_token     o_tok
);

    // Decode one hex digit; bit 4 is set only for 0-9, A-F or a-f
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (b >= 8'h30 && b <= 8'h39) begin
                d = b - 8'h30;
                hex_decode = {1'b1, d[3:0]};
            end else if (b >= 8'h41 && b <= 8'h46) begin
                d = b - 8'h37;
                hex_decode = {1'b1, d[3:0]};
            end else if (b >= 8'h61 && b <= 8'h66) begin
                d = b - 8'h57;
                hex_decode = {1'b1, d[3:0]};
            end else begin
                hex_decode = 5'd0;
            end
        end
    endfunction

    logic [4:0] hex;

    // Classify the incoming byte
    always_comb begin
        hex = hex_decode(i_data_byte);
        o_tok.data    = i_data_byte;
        o_tok.last    = i_last_byte;
        o_tok.hex_ok  = hex[4];
        o_tok.hex_val = hex[3:0];
        priority if (i_data_byte == CH_AMP) begin
            o_tok.kind = K_AMP;
        end else if (i_data_byte == CH_EQ) begin
            o_tok.kind = K_EQ;
        end else if (i_data_byte == CH_PLUS) begin
            o_tok.kind = K_PLUS;
        end else if (i_data_byte == CH_PCT) begin
            o_tok.kind = K_PCT;
        end else begin
            o_tok.kind = K_OTHER;
        end
    end

    // Accept when the token queue has room
    assign o_wr = i_push & ~i_full;

endmodule

[rtl/fubd_tok_queue.sv]
module fubd_tok_queue
    import fubd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_token i_tok,
    output logic   o_full,
    output logic   o_valid,
    output t_token o_tok,
    input  logic   i_take
);

    t_token            r_mem [TQ_DEPTH];
    logic [TQ_AW-1:0]  r_wp, r_rp, n_wp, n_rp;
    logic [TQ_CW-1:0]  r_cnt, n_cnt;
    logic              rd;

    assign o_full  = (r_cnt == TQ_CW'(TQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rp];
    assign rd      = i_take & o_valid;

    // Advance pointers and count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = (r_wp == TQ_AW'(TQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd) begin
            n_rp = (r_rp == TQ_AW'(TQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Hold token storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_tok;
        end
    end

endmodule

[rtl/fubd_back.sv]
module fubd_back
    import fubd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tok_valid,
    input  t_token  i_tok,
    output logic    o_take,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    // Parser state
    logic             r_part, n_part;
    logic [1:0]       r_phase, n_phase;
    logic [3:0]       r_nib, n_nib;
    logic             r_hold, n_hold;

    // Result queue
    t_result          r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_owp, r_orp;
    logic [OQ_CW-1:0] r_ocnt;

    logic             cv, ne, pe, res_valid, wr, rd;
    logic [7:0]       ob;
    logic [2:0]       err;
    logic [1:0]       phase;
    t_result          res;

    assign o_take  = i_tok_valid && (r_ocnt != OQ_CW'(OQ_DEPTH));
    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_oq[r_orp];
    assign rd      = i_pop && !o_empty;

    // Work out the next state and the result of one token
    always_comb begin
        phase   = (r_phase == PH_HIGH || r_phase == PH_LOW) ? r_phase : PH_IDLE;
        cv      = 1'b0;
        ob      = 8'd0;
        ne      = 1'b0;
        pe      = 1'b0;
        err     = ERR_NONE;
        n_part  = r_part;
        n_phase = phase;
        n_nib   = r_nib;
        n_hold  = r_hold;

        unique case (phase)
            PH_IDLE: begin
                unique case (i_tok.kind)
                    K_AMP: begin
                        if (!r_part) err = ERR_NO_EQ;
                        else         pe  = 1'b1;
                    end
                    K_EQ: begin
                        if (!r_part) begin
                            ne     = 1'b1;
                            n_part = 1'b1;
                        end else begin
                            err = ERR_EXTRA_EQ;
                        end
                    end
                    K_PLUS: begin
                        cv = 1'b1;
                        ob = CH_SPACE;
                    end
                    K_PCT: begin
                        n_phase = PH_HIGH;
                    end
                    default: begin
                        cv = 1'b1;
                        ob = i_tok.data;
                    end
                endcase
            end
            PH_HIGH: begin
                if (!i_tok.hex_ok) begin
                    err = ERR_BAD_HEX;
                end else begin
                    n_nib   = i_tok.hex_val;
                    n_phase = PH_LOW;
                end
            end
            default: begin
                if (!i_tok.hex_ok) begin
                    err = ERR_BAD_HEX;
                end else begin
                    cv      = 1'b1;
                    ob      = {r_nib, i_tok.hex_val};
                    n_phase = PH_IDLE;
                end
            end
        endcase

        // Close the body on the final byte
        if (err == ERR_NONE && i_tok.last) begin
            if (n_phase != PH_IDLE) begin
                err = ERR_TRUNC;
            end else if (!pe) begin
                if (!n_part) err = ERR_NO_EQ;
                else         pe  = 1'b1;
            end
        end

        if (err != ERR_NONE) begin
            cv      = 1'b0;
            ob      = 8'd0;
            ne      = 1'b0;
            pe      = 1'b0;
            n_part  = 1'b0;
            n_phase = PH_IDLE;
            n_nib   = 4'd0;
            n_hold  = !i_tok.last;
        end else begin
            if (pe) begin
                n_part  = 1'b0;
                n_phase = PH_IDLE;
            end
            if (i_tok.last) begin
                n_part  = 1'b0;
                n_phase = PH_IDLE;
                n_nib   = 4'd0;
                n_hold  = 1'b0;
            end
        end

        res_valid = cv || ne || pe || (err != ERR_NONE);

        // Drop bytes silently while an error is held
        if (r_hold) begin
            res_valid = 1'b0;
            n_part    = r_part;
            n_phase   = r_phase;
            n_nib     = r_nib;
            n_hold    = 1'b1;
            if (i_tok.last) begin
                n_part  = 1'b0;
                n_phase = PH_IDLE;
                n_nib   = 4'd0;
                n_hold  = 1'b0;
            end
        end

        res.char_valid = cv;
        res.out_byte   = ob;
        res.in_value   = r_part;
        res.name_end   = ne;
        res.pair_end   = pe;
        res.error_code = err;
        res.body_done  = i_tok.last;
    end

    assign wr = o_take && res_valid;

    // Advance parser and result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part  <= 1'b0;
            r_phase <= PH_IDLE;
            r_nib   <= 4'd0;
            r_hold  <= 1'b0;
            r_owp   <= '0;
            r_orp   <= '0;
            r_ocnt  <= '0;
        end else begin
            if (o_take) begin
                r_part  <= n_part;
                r_phase <= n_phase;
                r_nib   <= n_nib;
                r_hold  <= n_hold;
            end
            if (wr) begin
                r_owp <= (r_owp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_owp + 1'b1;
            end
            if (rd) begin
                r_orp <= (r_orp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_orp + 1'b1;
            end
            if (wr && !rd) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (!wr && rd) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

    // Hold result storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_oq[r_owp] <= res;
        end
    end

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("escape phase left its legal codes");

    a_hold_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_hold) |-> !wr)
        else $error("result produced while dropping an errored body");

    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && res.error_code != ERR_NONE && !i_tok.last) |=> r_hold)
        else $error("error on a middle byte did not enter hold");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_tok.last) |=> (!r_hold && !r_part && r_phase == PH_IDLE))
        else $error("final byte did not re-arm the parser");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt == OQ_CW'(OQ_DEPTH)) |=> (r_ocnt <= OQ_CW'(OQ_DEPTH)))
        else $error("result queue overran");

endmodule

[rtl/form_urlencoded_body_decoder.sv]
// Urlencoded form body decoder. Body bytes are pushed one per clock while
// full is low, with a flag on the final byte; each byte gives at most one
// result, which is popped from the result side. A front stage classifies
// each byte (delimiter or hex digit) into a four-entry token queue, and a
// back stage runs the name/value parser and writes results into a
// two-entry result queue, so one byte per cycle is sustained while results
// are popped every cycle. A result is ready to pop once its byte has passed
// the token queue register and then the result queue register. A '%' or a
// first hex digit that does not end the body gives no result; after an
// error the rest of the body up to the final byte is dropped with no results.
module form_urlencoded_body_decoder
    import fubd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_char_valid,
    output logic [7:0] o_out_byte,
    output logic       o_in_value,
    output logic       o_name_end,
    output logic       o_pair_end,
    output logic [2:0] o_error_code,
    output logic       o_body_done
);

    logic    tq_wr, tq_valid, tq_take;
    t_token  fe_tok, tq_tok;
    t_result res;

    // Classify bytes
    fubd_front u_front (
        .i_push      (push),
        .i_full      (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_wr        (tq_wr),
        .o_tok       (fe_tok)
    );

    // Decouple front and back
    fubd_tok_queue u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (tq_wr),
        .i_tok   (fe_tok),
        .o_full  (full),
        .o_valid (tq_valid),
        .o_tok   (tq_tok),
        .i_take  (tq_take)
    );

    // Parse and queue results
    fubd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tq_valid),
        .i_tok       (tq_tok),
        .o_take      (tq_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_char_valid = res.char_valid;
    assign o_out_byte   = res.out_byte;
    assign o_in_value   = res.in_value;
    assign o_name_end   = res.name_end;
    assign o_pair_end   = res.pair_end;
    assign o_error_code = res.error_code;
    assign o_body_done  = res.body_done;

endmodule

[test/tb_form_urlencoded_body_decoder.sv]
`timescale 1ns / 1ps

module tb_form_urlencoded_body_decoder
    import fubd_pkg::*;
();

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_SLACK = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int N_PHASES = 4;

    // Decoder model plus store of the results it still owes
    class body_decode_checker;
        logic       value_part = 1'b0;
        logic [1:0] esc_phase  = PH_IDLE;
        logic [3:0] hi_nibble  = 4'h0;
        logic       dropping   = 1'b0;
        t_result    want_results[$];
        int         n_bytes = 0;
        int         n_checked = 0;
        int         n_mismatch = 0;
        int         n_err[5] = '{default: 0};

        function void clear_body();
            value_part = 1'b0;
            esc_phase  = PH_IDLE;
            hi_nibble  = 4'h0;
            dropping   = 1'b0;
        endfunction

        // Bit 4 set when the byte is not a hex digit
        function logic [4:0] hex_value(logic [7:0] b);
            logic [7:0] d;
            if (b >= 8'h30 && b <= 8'h39) d = b - 8'h30;
            else if (b >= 8'h41 && b <= 8'h46) d = b - 8'h37;
            else if (b >= 8'h61 && b <= 8'h66) d = b - 8'h57;
            else return 5'h10;
            return {1'b0, d[3:0]};
        endfunction

        // Render one result for a report line
        function string describe(t_result r);
            return $sformatf("cv=%0d byte=%02h val=%0d ne=%0d pe=%0d err=%0d done=%0d",
                             r.char_valid, r.out_byte, r.in_value, r.name_end,
                             r.pair_end, r.error_code, r.body_done);
        endfunction

        // Advance the parser by one accepted byte and queue any result it owes
        function void take_byte(logic [7:0] b, logic last);
            t_result    r;
            logic [1:0] ph;
            logic [4:0] hx;
            logic       part_in;
            n_bytes++;
            if (dropping) begin
                if (last) clear_body();
                return;
            end
            r = '0;
            part_in = value_part;
            ph = esc_phase;
            if (ph != PH_HIGH && ph != PH_LOW) ph = PH_IDLE;

            case (ph)
                PH_IDLE: begin
                    if (b == CH_AMP) begin
                        if (!value_part) r.error_code = ERR_NO_EQ;
                        else r.pair_end = 1'b1;
                    end else if (b == CH_EQ) begin
                        if (!value_part) begin
                            r.name_end = 1'b1;
                            value_part = 1'b1;
                        end else begin
                            r.error_code = ERR_EXTRA_EQ;
                        end
                    end else if (b == CH_PLUS) begin
                        r.char_valid = 1'b1;
                        r.out_byte = CH_SPACE;
                    end else if (b == CH_PCT) begin
                        ph = PH_HIGH;
                    end else begin
                        r.char_valid = 1'b1;
                        r.out_byte = b;
                    end
                end
                PH_HIGH: begin
                    hx = hex_value(b);
                    if (hx[4]) begin
                        r.error_code = ERR_BAD_HEX;
                    end else begin
                        hi_nibble = hx[3:0];
                        ph = PH_LOW;
                    end
                end
                default: begin
                    hx = hex_value(b);
                    if (hx[4]) begin
                        r.error_code = ERR_BAD_HEX;
                    end else begin
                        r.char_valid = 1'b1;
                        r.out_byte = {hi_nibble, hx[3:0]};
                        ph = PH_IDLE;
                    end
                end
            endcase
            esc_phase = ph;

            // Close the body on its final byte
            if (r.error_code == ERR_NONE && last) begin
                if (ph != PH_IDLE) r.error_code = ERR_TRUNC;
                else if (!r.pair_end) begin
                    if (!value_part) r.error_code = ERR_NO_EQ;
                    else r.pair_end = 1'b1;
                end
            end

            if (r.error_code != ERR_NONE) begin
                r.char_valid = 1'b0;
                r.out_byte = 8'h00;
                r.name_end = 1'b0;
                r.pair_end = 1'b0;
                clear_body();
                dropping = !last;
            end else begin
                if (r.pair_end) begin
                    value_part = 1'b0;
                    esc_phase = PH_IDLE;
                end
                if (last) clear_body();
            end

            r.in_value = part_in;
            r.body_done = last;
            if (r.char_valid || r.name_end || r.pair_end || r.error_code != ERR_NONE)
                want_results = {want_results, r};
        endfunction

        // Compare a popped result with the oldest one owed
        function void check_result(t_result got);
            t_result want;
            if (want_results.size() == 0) begin
                if (n_mismatch < 10)
                    $display("%0t: unexpected result %s", $time, describe(got));
                n_mismatch++;
                return;
            end
            want = want_results.pop_front();
            n_checked++;
            if (want.error_code <= ERR_EXTRA_EQ) n_err[want.error_code]++;
            if (got !== want) begin
                if (n_mismatch < 10) begin
                    $display("%0t: mismatch exp %s", $time, describe(want));
                    $display("          got %s", describe(got));
                end
                n_mismatch++;
            end
        endfunction

        function int outstanding();
            return want_results.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_char_valid;
    logic [7:0] o_out_byte;
    logic       o_in_value;
    logic       o_name_end;
    logic       o_pair_end;
    logic [2:0] o_error_code;
    logic       o_body_done;

    body_decode_checker decoder_chk = new();

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int bodies_sent = 0;
    int idle_cycles = 0;
    int full_cycles = 0;

    form_urlencoded_body_decoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .empty        (empty),
        .pop          (pop),
        .o_char_valid (o_char_valid),
        .o_out_byte   (o_out_byte),
        .o_in_value   (o_in_value),
        .o_name_end   (o_name_end),
        .o_pair_end   (o_pair_end),
        .o_error_code (o_error_code),
        .o_body_done  (o_body_done)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Pop side: check each transfer, then stall or hold off for the next cycle
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && pop && !empty) begin
            got.char_valid = o_char_valid;
            got.out_byte   = o_out_byte;
            got.in_value   = o_in_value;
            got.name_end   = o_name_end;
            got.pair_end   = o_pair_end;
            got.error_code = o_error_code;
            got.body_done  = o_body_done;
            decoder_chk.check_result(got);
        end
        if (rx_hold_left > 0) begin
            pop <= 1'b0;
            rx_hold_left--;
        end else begin
            pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && full) full_cycles++;
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("[form_urlencoded_body_decoder] ERROR");
                    $finish;
                end
            end
        end
    end

    // Offer one byte after a random idle stretch and hold it until transferred
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (full);
        decoder_chk.take_byte(b, last);
    endtask

    task automatic send_body(input logic [7:0] body[$]);
        for (int i = 0; i < body.size(); i++)
            send_byte(body[i], i == body.size() - 1);
        bodies_sent++;
    endtask

    task automatic send_text(input string s);
        logic [7:0] body[$];
        for (int i = 0; i < s.len(); i++) body = {body, s[i]};
        send_body(body);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, logic upper);
        if (n < 4'd10) return 8'h30 + n;
        return (upper ? 8'h37 : 8'h57) + n;
    endfunction

    // One piece of a name or value: plain byte, plus, or percent escape
    function automatic void add_token(ref logic [7:0] body[$]);
        logic [7:0] b;
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            body = {body, CH_PLUS};
        end else if (pick <= 3) begin
            body = {body, CH_PCT};
            body = {body, hex_char(4'($urandom_range(15)), 1'($urandom_range(1)))};
            body = {body, hex_char(4'($urandom_range(15)), 1'($urandom_range(1)))};
        end else begin
            do b = 8'($urandom_range(255));
            while (b == CH_AMP || b == CH_EQ || b == CH_PLUS || b == CH_PCT);
            body = {body, b};
        end
    endfunction

    // Mostly well-formed bodies of pairs; the rest is delimiter-heavy noise
    task automatic send_random_body();
        logic [7:0] body[$];
        int n_pairs;
        int n_tok;
        if ($urandom_range(99) < 80) begin
            n_pairs = $urandom_range(1, 4);
            for (int p = 0; p < n_pairs; p++) begin
                if (p != 0) body = {body, CH_AMP};
                n_tok = $urandom_range(0, 3);
                for (int t = 0; t < n_tok; t++) add_token(body);
                body = {body, CH_EQ};
                n_tok = $urandom_range(0, 3);
                for (int t = 0; t < n_tok; t++) add_token(body);
            end
        end else begin
            n_tok = $urandom_range(1, 12);
            for (int t = 0; t < n_tok; t++) begin
                case ($urandom_range(7))
                    0: body = {body, CH_AMP};
                    1: body = {body, CH_EQ};
                    2: body = {body, CH_PLUS};
                    3: body = {body, CH_PCT};
                    4: body = {body, hex_char(4'($urandom_range(15)),
                                              1'($urandom_range(1)))};
                    default: body = {body, 8'($urandom_range(255))};
                endcase
            end
        end
        send_body(body);
    endtask

    // Drop push and wait until every owed result has been popped
    task automatic drain();
        push <= 1'b0;
        while (decoder_chk.outstanding() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] raw[$];
        int tx_pct[N_PHASES];
        int rx_pct[N_PHASES];
        int target;

        tx_pct = '{0, 85, 0, 22};
        rx_pct = '{0, 0, 85, 22};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed bodies: escapes in both cases, delimiters and each error path
        send_text("%4a=+%Ff&=");
        send_text("%9");
        send_text("%&q");
        send_text("&");
        send_text("==0");
        send_text("x");
        raw = {8'hFF, CH_EQ, CH_PCT, 8'h67};
        send_body(raw);
        raw = {CH_EQ, 8'h00};
        send_body(raw);
        drain();

        // Random bodies under each idling mix
        for (int ph = 0; ph < N_PHASES; ph++) begin
            tx_idle_pct = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            target = decoder_chk.n_bytes + ITEMS_PER_PHASE;
            while (decoder_chk.n_bytes < target) send_random_body();
            drain();
        end

        // Hold off the pop side while bytes keep coming, so the input backs up
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_left = HOLD_OFF_CYCLES;
        target = decoder_chk.n_bytes + 60;
        while (decoder_chk.n_bytes < target) send_random_body();
        drain();

        repeat (DRAIN_SLACK) @(posedge i_clk);

        $display("Sent %0d bodies (%0d bytes), checked %0d results, input full for %0d cycles",
                 bodies_sent, decoder_chk.n_bytes, decoder_chk.n_checked, full_cycles);
        $display("Errors seen: bad hex %0d, truncated %0d, no '=' %0d, extra '=' %0d",
                 decoder_chk.n_err[ERR_BAD_HEX], decoder_chk.n_err[ERR_TRUNC],
                 decoder_chk.n_err[ERR_NO_EQ], decoder_chk.n_err[ERR_EXTRA_EQ]);
        if (decoder_chk.n_mismatch == 0 && decoder_chk.outstanding() == 0) begin
            $display("[form_urlencoded_body_decoder] OK");
        end else begin
            $display("[form_urlencoded_body_decoder] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/fubd_pkg.sv
rtl/fubd_front.sv
rtl/fubd_tok_queue.sv
rtl/fubd_back.sv
rtl/form_urlencoded_body_decoder.sv
test/tb_form_urlencoded_body_decoder.sv
